/* rtl/core/snrmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snrmf_pkg
// Shared types and constants of the sonar range median filter.
// ----------------------------------------------------------------------------
package snrmf_pkg;

    localparam int RANGE_W        = 14;
    localparam int WINDOW_MAX_DEF = 16;
    localparam int WIDTH_REG_W    = 5;
    localparam int COEF_W         = 16;
    localparam int OFFS_W         = 15;
    localparam int ALT_W          = 16;
    localparam int FWD_W          = 15;
    localparam int GROUP_W        = 16;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_DATA_W     = 120;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // window fill value after reset
    localparam logic [RANGE_W-1:0] RESET_MAX_RANGE = 14'h3FFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINE_COEF       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COSINE_COEF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE_OFFSET = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE0,
        ST_RANK,
        ST_MUL,
        ST_POST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MS_RAW_SIN,
        MS_RAW_COS,
        MS_MED_SIN,
        MS_MED_COS
    } t_mul_slot;

endpackage
`default_nettype wire

/* rtl/core/sonar_range_median_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_range_median_filter_top
// Sliding-window median filter of sonar ranges with altitude and forward terms.
// ----------------------------------------------------------------------------
// The input stream carries the two range bytes of a reply (low byte in bits
// 7:0). A reading below min_range is taken and dropped without a result. Any
// other reading is shifted into a window held in a one-port synchronous RAM,
// the median is found by a rank count that streams the window through one read
// port, and four products share one multiplier. One result leaves on the
// output stream per kept reading. The user must write registers on the cfg
// channel only while the block is idle; the block does not enforce this.
// cfg is always ready. The rank count over the RAM read port is the longest
// part of the work on a reading. One reading is in work at a time.
// At reset every window entry reads as 16383 through per-entry valid bits, so
// no clearing pass is needed and input can be taken straight after reset.
// A stalled output holds its result; the next reading is taken and worked on
// and waits in its final step until the output register is free.
// ----------------------------------------------------------------------------
module sonar_range_median_filter_top
    import snrmf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] range_byte_low, [15:8] range_byte_high
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // [13:0] raw_range, [27:14] median_range, [41:28] filtered_range,
    // [57:42] raw_altitude, [72:58] raw_forward, [88:73] filtered_altitude,
    // [103:89] filtered_forward, [119:104] group_index
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int EXT_W  = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
    localparam int PROD_W = RANGE_W + 1 + COEF_W;
    localparam int QUOT_W = PROD_W + 1 - 15;
    localparam int DIFF_W = QUOT_W + 1;

    // configuration
    logic [WIDTH_REG_W-1:0]   r_width;
    logic [RANGE_W-1:0]       r_min;
    logic [RANGE_W-1:0]       r_max;
    logic signed [COEF_W-1:0] r_sin;
    logic signed [COEF_W-1:0] r_cos;
    logic signed [OFFS_W-1:0] r_offs;

    // window memory
    logic [RANGE_W-1:0]    r_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] r_vld;
    logic [RANGE_W-1:0]    r_rd_data;
    logic                  r_rd_vld;
    logic                  s_rd_en;
    logic [ADDR_W-1:0]     s_rd_addr;
    logic                  s_wr_en;
    logic [ADDR_W-1:0]     s_wr_addr;
    logic [RANGE_W-1:0]    s_wr_data;
    logic [RANGE_W-1:0]    s_rd_q;

    t_state r_state, n_state;

    logic [RANGE_W-1:0] r_raw;
    logic [CNT_W-1:0]   r_w;
    logic [CNT_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_si;
    logic [CNT_W-1:0]   r_ci;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   r_less;
    logic [CNT_W-1:0]   r_leq;
    logic [RANGE_W-1:0] r_cand;
    logic [RANGE_W-1:0] r_med;
    logic               r_tag_vld;
    logic               r_tag_cand;
    logic               r_tag_last;
    logic [CNT_W-1:0]   r_phase;
    logic [GROUP_W-1:0] r_group;

    t_mul_slot                r_mi;
    t_mul_slot                r_pslot;
    logic                     r_pvld;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [ALT_W-1:0] r_ralt;
    logic signed [FWD_W-1:0] r_rfwd;
    logic signed [ALT_W-1:0] r_falt;
    logic signed [FWD_W-1:0] r_ffwd;

    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [RANGE_W-1:0] s_raw;
    logic               s_acc;
    logic               s_keep;
    logic [EXT_W-1:0]   s_wext;
    logic [CNT_W-1:0]   s_eff_w;
    logic               s_lt;
    logic               s_le;
    logic [CNT_W-1:0]   s_less_n;
    logic [CNT_W-1:0]   s_leq_n;
    logic               s_found;
    logic               s_out_fire;
    logic               s_in_bounds;
    logic [CNT_W:0]     s_phase_inc;

    logic [RANGE_W-1:0]       s_op;
    logic signed [COEF_W-1:0] s_coef;
    logic signed [PROD_W:0]   s_rsum;
    logic signed [QUOT_W-1:0] s_q;
    logic signed [DIFF_W-1:0] s_alt;
    logic signed [ALT_W-1:0]  s_alt_sat;
    logic signed [FWD_W-1:0]  s_fwd_sat;

    logic [RANGE_W-1:0]      s_filt;
    logic signed [ALT_W-1:0] s_falt_o;
    logic signed [FWD_W-1:0] s_ffwd_o;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // bit 7 of both bytes is unused
    assign s_raw  = {i_s_axis_tdata[14:8], i_s_axis_tdata[6:0]};
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_keep = s_acc && (s_raw >= r_min);

    always_comb begin
        s_wext = EXT_W'(r_width);
        if (r_width == '0) begin
            s_eff_w = CNT_W'(1);
        end else if (s_wext > EXT_W'(WINDOW_MAX)) begin
            s_eff_w = CNT_W'(WINDOW_MAX);
        end else begin
            s_eff_w = CNT_W'(s_wext);
        end
    end

    // entries never written since reset read as the reset fill
    assign s_rd_q = r_rd_vld ? r_rd_data : RESET_MAX_RANGE;

    // rank count against the held candidate
    assign s_lt     = (s_rd_q < r_cand);
    assign s_le     = (s_rd_q <= r_cand);
    assign s_less_n = r_less + CNT_W'(s_lt);
    assign s_leq_n  = r_leq + CNT_W'(s_le);
    assign s_found  = r_tag_vld && !r_tag_cand && r_tag_last
                      && (s_less_n <= r_k) && (r_k < s_leq_n);

    assign s_out_fire  = !r_out_vld || i_m_axis_tready;
    assign s_phase_inc = {1'b0, r_phase} + (CNT_W + 1)'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_keep) begin
                    n_state = (s_eff_w > CNT_W'(1)) ? ST_SHIFT_RD : ST_WRITE0;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: n_state = (r_si == CNT_W'(1)) ? ST_WRITE0 : ST_SHIFT_RD;
            ST_WRITE0:   n_state = ST_RANK;
            ST_RANK: begin
                if (s_found) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_mi == MS_MED_COS) begin
                    n_state = ST_POST;
                end
            end
            ST_POST:     n_state = ST_DONE;
            ST_DONE: begin
                if (s_out_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        s_rd_en   = 1'b0;
        s_rd_addr = '0;
        s_wr_en   = 1'b0;
        s_wr_addr = '0;
        s_wr_data = r_raw;
        unique case (r_state)
            ST_SHIFT_RD: begin
                s_rd_en   = 1'b1;
                s_rd_addr = ADDR_W'(r_si - CNT_W'(1));
            end
            ST_SHIFT_WR: begin
                s_wr_en   = 1'b1;
                s_wr_addr = ADDR_W'(r_si);
                s_wr_data = s_rd_q;
            end
            ST_WRITE0: begin
                s_wr_en   = 1'b1;
                s_wr_addr = '0;
                s_wr_data = r_raw;
            end
            ST_RANK: begin
                s_rd_en   = 1'b1;
                s_rd_addr = (r_j == '0) ? ADDR_W'(r_ci) : ADDR_W'(r_j - CNT_W'(1));
            end
            ST_IDLE, ST_MUL, ST_POST, ST_DONE: begin
                s_rd_en = 1'b0;
            end
            default: begin
                s_rd_en = 1'b0;
            end
        endcase
    end

    // window memory with registered read
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[s_wr_addr] <= s_wr_data;
        end
        if (s_rd_en) begin
            r_rd_data <= r_mem[s_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (s_wr_en) begin
                r_vld[s_wr_addr] <= 1'b1;
            end
            if (s_rd_en) begin
                r_rd_vld <= r_vld[s_rd_addr];
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_REG_W'(5);
            r_min   <= '0;
            r_max   <= RESET_MAX_RANGE;
            r_sin   <= '0;
            r_cos   <= COEF_W'(32767);
            r_offs  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_WIDTH:    r_width <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_MIN_RANGE:       r_min   <= i_cfg_data[RANGE_W-1:0];
                CFG_MAX_RANGE:       r_max   <= i_cfg_data[RANGE_W-1:0];
                CFG_SINE_COEF:       r_sin   <= i_cfg_data[COEF_W-1:0];
                CFG_COSINE_COEF:     r_cos   <= i_cfg_data[COEF_W-1:0];
                CFG_ALTITUDE_OFFSET: r_offs  <= i_cfg_data[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tag_vld <= 1'b0;
            r_pvld    <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= '0;
            r_group   <= '0;
        end else begin
            r_state   <= n_state;
            r_tag_vld <= (r_state == ST_RANK) && (n_state == ST_RANK);
            r_pvld    <= (r_state == ST_MUL);
            if (r_state == ST_WRITE0) begin
                if (s_phase_inc >= {1'b0, r_w}) begin
                    r_phase <= '0;
                    r_group <= r_group + GROUP_W'(1);
                end else begin
                    r_phase <= s_phase_inc[CNT_W-1:0];
                end
            end
            if (r_state == ST_DONE && s_out_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // multiplier operands
    always_comb begin
        s_op   = r_raw;
        s_coef = r_sin;
        unique case (r_mi)
            MS_RAW_SIN: begin s_op = r_raw; s_coef = r_sin; end
            MS_RAW_COS: begin s_op = r_raw; s_coef = r_cos; end
            MS_MED_SIN: begin s_op = r_med; s_coef = r_sin; end
            MS_MED_COS: begin s_op = r_med; s_coef = r_cos; end
            default:    begin s_op = r_raw; s_coef = r_sin; end
        endcase
    end

    // round half up, subtract offset (altitude only), saturate
    always_comb begin
        s_rsum = {r_prod[PROD_W-1], r_prod} + (PROD_W + 1)'(16384);
        s_q    = s_rsum[PROD_W:15];
        s_alt  = {s_q[QUOT_W-1], s_q}
                 - {{(DIFF_W - OFFS_W){r_offs[OFFS_W-1]}}, r_offs};
        if (s_alt > DIFF_W'(32767)) begin
            s_alt_sat = ALT_W'(32767);
        end else if (s_alt < -(DIFF_W'(32768))) begin
            s_alt_sat = ALT_W'(32768);
        end else begin
            s_alt_sat = s_alt[ALT_W-1:0];
        end
        if (s_q > QUOT_W'(16383)) begin
            s_fwd_sat = FWD_W'(16383);
        end else if (s_q < -(QUOT_W'(16384))) begin
            s_fwd_sat = FWD_W'(16384);
        end else begin
            s_fwd_sat = s_q[FWD_W-1:0];
        end
    end

    // median path: a median outside (min_range, max_range) is replaced by max_range
    always_comb begin
        s_in_bounds = (r_med > r_min) && (r_med < r_max);
        if (s_in_bounds) begin
            s_filt   = r_med;
            s_falt_o = r_falt;
            s_ffwd_o = r_ffwd;
        end else begin
            s_filt   = r_max;
            s_falt_o = {{(ALT_W - RANGE_W){1'b0}}, r_max};
            s_ffwd_o = {{(FWD_W - RANGE_W){1'b0}}, r_max};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_keep) begin
            r_raw <= s_raw;
            r_w   <= s_eff_w;
            r_k   <= s_eff_w >> 1;
            r_si  <= s_eff_w - CNT_W'(1);
        end
        if (r_state == ST_SHIFT_WR) begin
            r_si <= r_si - CNT_W'(1);
        end
        if (r_state == ST_WRITE0) begin
            r_ci <= '0;
            r_j  <= '0;
            r_mi <= MS_RAW_SIN;
        end
        if (r_state == ST_RANK) begin
            r_tag_cand <= (r_j == '0);
            r_tag_last <= (r_j == r_w);
            if (r_j == r_w) begin
                r_j  <= '0;
                r_ci <= r_ci + CNT_W'(1);
            end else begin
                r_j <= r_j + CNT_W'(1);
            end
            if (r_tag_vld) begin
                if (r_tag_cand) begin
                    r_cand <= s_rd_q;
                    r_less <= '0;
                    r_leq  <= '0;
                end else begin
                    r_less <= s_less_n;
                    r_leq  <= s_leq_n;
                end
            end
            if (s_found) begin
                r_med <= r_cand;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod  <= $signed({1'b0, s_op}) * s_coef;
            r_pslot <= r_mi;
            r_mi    <= t_mul_slot'(r_mi + 2'd1);
        end
        if (r_pvld) begin
            unique case (r_pslot)
                MS_RAW_SIN: r_ralt <= s_alt_sat;
                MS_RAW_COS: r_rfwd <= s_fwd_sat;
                MS_MED_SIN: r_falt <= s_alt_sat;
                MS_MED_COS: r_ffwd <= s_fwd_sat;
                default:    r_ralt <= s_alt_sat;
            endcase
        end
        if (r_state == ST_DONE && s_out_fire) begin
            r_out_data <= {r_group, s_ffwd_o, s_falt_o, r_rfwd, r_ralt,
                           s_filt, r_med, r_raw};
        end
    end

endmodule
`default_nettype wire
